// ----- hdl/contiguous_frame_ring_allocator_macros.svh -----
// assertion macros for the frame ring allocator
`ifndef CONTIGUOUS_FRAME_RING_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FRAME_RING_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define CFRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cfra check failed");

// next-cycle implication, checked outside reset
`define CFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfra check failed");

`endif

// ----- hdl/cfra_pkg.sv -----
// shared types and constants for the frame ring allocator
`default_nettype none
package cfra_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int RING_W = 17;
	localparam int ALIGN_W = 4;
	localparam int BYTES_W = 16;
	localparam int FIELD_OFF_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = RING_W;

	localparam logic [RING_W-1:0] RING_BYTES_RST = 17'd65536;
	localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RST = 4'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_RING_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = 1'd1;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_DISCARD = 2'd1,
		CMD_WRAP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_OVERRUN = 2'd3
	} status_t;

endpackage
`default_nettype wire

// ----- hdl/cfra_if.sv -----
// request and response channel interfaces of the frame ring allocator
`default_nettype none
interface cfra_req_if
	import cfra_pkg::*;
();
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [BYTES_W-1:0] frame_bytes;

	modport source (output valid, cmd, frame_bytes, input ready);
	modport sink (input valid, cmd, frame_bytes, output ready);
endinterface

interface cfra_rsp_if
	import cfra_pkg::*;
();
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [FIELD_OFF_W-1:0] frame_offset;
	logic marker_write;
	logic [FIELD_OFF_W-1:0] marker_offset;

	modport source (output valid, status, frame_offset, marker_write, marker_offset,
		input ready);
	modport sink (input valid, status, frame_offset, marker_write, marker_offset,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/contiguous_frame_ring_allocator.sv -----
// contiguous frame ring allocator: offsets, size rounding and grant logic
// an item is registered at the input stage, decided in one pass, and its result is
// registered in the result stage; throughput: one item per cycle unless the response
// channel stalls; each item is one compare-and-update of the offsets
// reset (arst_n low): offsets cleared, ring_bytes 65536, align_log2 3, channels empty
// any configuration write also clears both offsets (a new, empty ring)
`default_nettype none
`include "contiguous_frame_ring_allocator_macros.svh"
module contiguous_frame_ring_allocator
	import cfra_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	cfra_req_if.sink req,
	cfra_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	// working width: room for capacity plus a size without overflow
	localparam int CW = ((OFFSET_BITS + 1 > RING_W) ? OFFSET_BITS + 1 : RING_W) + 2;

	// configuration registers
	logic [RING_W-1:0] ring_bytes_q;
	logic [ALIGN_W-1:0] align_log2_q;

	// ring state
	logic [OFFSET_BITS-1:0] rd_q, wr_q;
	logic [OFFSET_BITS-1:0] rd_nxt, wr_nxt;

	// input stage
	logic valid_s1;
	logic [1:0] cmd_s1;
	logic [BYTES_W-1:0] bytes_s1;

	// result stage
	logic valid_s2;
	status_t status_s2;
	logic [FIELD_OFF_W-1:0] off_s2;
	logic mk_s2;
	logic [FIELD_OFF_W-1:0] mkoff_s2;

	// handshake: the result register frees when taken, the input stage when it moves on
	logic adv_s1;
	assign adv_s1 = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;

	// size rounding and capacity
	logic [RING_W-1:0] align_mask;
	logic [RING_W-1:0] size_sum;
	logic [CW-1:0] sz, cap, lim, rb, rd_w, wr_w, q_disc;

	assign align_mask = (RING_W'(1) << align_log2_q) - RING_W'(1);
	assign size_sum = RING_W'(bytes_s1) + align_mask;
	assign sz = CW'(size_sum & ~align_mask);

	assign lim = CW'(1) << OFFSET_BITS;
	assign rb = CW'(ring_bytes_q);
	assign cap = (rb > lim) ? lim : rb;
	assign rd_w = CW'(rd_q);
	assign wr_w = CW'(wr_q);
	assign q_disc = rd_w + sz;

	// one-pass decision
	logic produce;
	status_t status_c;
	logic [CW-1:0] off_c, wr_sum;
	logic mk_c;
	logic [CW-1:0] mkoff_c;

	always_comb begin
		produce = 1'b1;
		status_c = ST_OK;
		off_c = '0;
		mk_c = 1'b0;
		mkoff_c = '0;
		rd_nxt = rd_q;
		wr_nxt = wr_q;
		wr_sum = '0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (sz >= cap) begin
					status_c = ST_TOO_LARGE;
				end else if (rd_w > wr_w) begin
					// free gap lies between the write and read offsets
					if (sz < rd_w - wr_w) begin
						off_c = wr_w;
						wr_sum = wr_w + sz;
						wr_nxt = (wr_sum == cap) ? '0 : OFFSET_BITS'(wr_sum);
					end else begin
						status_c = ST_NO_ROOM;
					end
				end else if (wr_w < cap && sz < cap - wr_w) begin
					// fits before the end of the ring
					off_c = wr_w;
					wr_sum = wr_w + sz;
					wr_nxt = (wr_sum == cap) ? '0 : OFFSET_BITS'(wr_sum);
				end else if (sz < rd_w) begin
					// wrap: frame goes to the start, marker at the old write offset
					mk_c = 1'b1;
					mkoff_c = wr_w;
					off_c = '0;
					wr_nxt = (sz == cap) ? '0 : OFFSET_BITS'(sz);
				end else begin
					status_c = ST_NO_ROOM;
				end
			end
			CMD_DISCARD: begin
				if (q_disc > cap) begin
					status_c = ST_OVERRUN;
					off_c = rd_w;
				end else if (q_disc == cap) begin
					rd_nxt = '0;
					off_c = '0;
				end else begin
					rd_nxt = OFFSET_BITS'(q_disc);
					off_c = q_disc;
				end
			end
			CMD_WRAP: begin
				rd_nxt = '0;
			end
			default: begin
				// undefined command: dropped, no result
				produce = 1'b0;
			end
		endcase
	end

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1 <= req.cmd;
			bytes_s1 <= req.frame_bytes;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && produce) begin
			status_s2 <= status_c;
			off_s2 <= FIELD_OFF_W'(off_c);
			mk_s2 <= mk_c;
			mkoff_s2 <= FIELD_OFF_W'(mkoff_c);
		end
	end

	// configuration and ring state; the user writes only while idle, unenforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_bytes_q <= RING_BYTES_RST;
			align_log2_q <= ALIGN_LOG2_RST;
			rd_q <= '0;
			wr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RING_BYTES: ring_bytes_q <= cfg_data;
				CFG_ALIGN_LOG2: align_log2_q <= ALIGN_W'(cfg_data);
				default: ;
			endcase
			rd_q <= '0;
			wr_q <= '0;
		end else if (adv_s1 && valid_s1) begin
			rd_q <= rd_nxt;
			wr_q <= wr_nxt;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.status = status_s2;
	assign rsp.frame_offset = off_s2;
	assign rsp.marker_write = mk_s2;
	assign rsp.marker_offset = mkoff_s2;

	// offsets never reach the capacity
	`CFRA_ASSERT_NOW(a_wr_in_ring, clk, arst_n, 1'b1, (wr_q == '0) || (wr_w < cap))
	`CFRA_ASSERT_NOW(a_rd_in_ring, clk, arst_n, 1'b1, (rd_q == '0) || (rd_w < cap))
	// a wrap grant is an ok grant at the start, with the marker past the start
	`CFRA_ASSERT_NOW(a_marker_grant, clk, arst_n, valid_s2 && mk_s2,
		(status_s2 == ST_OK) && (off_s2 == '0) && (mkoff_s2 != '0))
	// offsets move only with an item or a configuration write
	`CFRA_ASSERT_NEXT(a_state_hold, clk, arst_n, !cfg_we && !(adv_s1 && valid_s1),
		$stable(rd_q) && $stable(wr_q))

endmodule
`default_nettype wire
